// File: rtl/csmv_pkg.sv
// Shared types and codes for the CSR sparse matrix-vector multiply block.
// Holds item, result and command structs plus mode and command codes.
// No dependencies.
package csmv_pkg;

    localparam int POS_W      = 21;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [1:0] MODE_LOAD_ENTRY  = 2'd0;
    localparam logic [1:0] MODE_LOAD_VECTOR = 2'd1;
    localparam logic [1:0] MODE_COMPUTE     = 2'd2;
    localparam logic [1:0] MODE_CLEAR       = 2'd3;

    localparam logic [1:0] CMD_APPEND    = 2'd0;
    localparam logic [1:0] CMD_VECTOR    = 2'd1;
    localparam logic [1:0] CMD_ROW       = 2'd2;
    localparam logic [1:0] CMD_EMPTY_ROW = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic [9:0]         result_row;
        logic signed [31:0] dot_value;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [9:0]       row;
        logic [9:0]       col;
        logic [31:0]      value;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } cmd_t;

endpackage

// File: rtl/csmv_front.sv
// Input side: accepts items, checks entry order and bounds, tracks the open row.
// Emits commands into the command queue. Depends on csmv_pkg.
module csmv_front
    import csmv_pkg::*;
#(
    parameter int ROWS    = 1024,
    parameter int COLS    = 1024,
    parameter int ENTRIES = 4096
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    output logic  full,
    input  logic  clearing,
    input  logic  cmdq_full,
    output logic  cmd_push,
    output cmd_t  cmd
);

    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ECW = $clog2(ENTRIES + 1);

    logic [ECW-1:0] cnt_reg, cnt_next;
    logic [9:0]     cur_row_reg, cur_row_next;
    logic [EAW-1:0] cur_start_reg, cur_start_next;
    logic [ECW-1:0] cur_len_reg, cur_len_next;

    logic           accept;
    logic           row_bad;
    logic           col_bad;
    logic           store_full;
    logic           out_of_order;
    logic           new_row;
    logic [EAW-1:0] start_sel;
    logic [ECW-1:0] len_sel;

    assign full         = cmdq_full || clearing;
    assign accept       = push && !full;
    assign row_bad      = 32'(item.row) >= 32'(ROWS);
    assign col_bad      = 32'(item.col) >= 32'(COLS);
    assign store_full   = cnt_reg == ECW'(ENTRIES);
    assign out_of_order = (cnt_reg != '0) && (item.row < cur_row_reg);
    assign new_row      = (cnt_reg == '0) || (item.row != cur_row_reg);
    assign start_sel    = new_row ? EAW'(cnt_reg) : cur_start_reg;
    assign len_sel      = new_row ? ECW'(1) : cur_len_reg + ECW'(1);

    always_comb
    begin
        cnt_next       = cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        cmd.row        = item.row;
        cmd.col        = item.col;
        cmd.value      = item.value;
        cmd.pos        = POS_W'(cnt_reg);
        cmd.start      = POS_W'(start_sel);
        cmd.len        = POS_W'(len_sel);
        if (accept)
        begin
            unique case (item.mode)
                MODE_LOAD_ENTRY:
                begin
                    if (!(row_bad || col_bad || store_full || out_of_order))
                    begin
                        cmd.kind       = CMD_APPEND;
                        cmd_push       = 1'b1;
                        cnt_next       = cnt_reg + ECW'(1);
                        cur_row_next   = item.row;
                        cur_start_next = start_sel;
                        cur_len_next   = len_sel;
                    end
                end
                MODE_LOAD_VECTOR:
                begin
                    if (!col_bad)
                    begin
                        cmd.kind = CMD_VECTOR;
                        cmd_push = 1'b1;
                    end
                end
                MODE_COMPUTE:
                begin
                    cmd.kind = row_bad ? CMD_EMPTY_ROW : CMD_ROW;
                    cmd_push = 1'b1;
                end
                MODE_CLEAR:
                begin
                    cnt_next     = '0;
                    cur_row_next = '0;
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cur_row_reg   <= '0;
            cur_start_reg <= '0;
            cur_len_reg   <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_start_reg <= cur_start_next;
            cur_len_reg   <= cur_len_next;
        end
    end

endmodule

// File: rtl/csmv_cmdq.sv
// Short command queue between the input side and the execution side.
// Depends on csmv_pkg for the command type and depth.
module csmv_cmdq
    import csmv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW:0]   cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = cnt_reg == (CMDQ_AW + 1)'(CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + (CMDQ_AW + 1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (CMDQ_AW + 1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: rtl/csmv_back.sv
// Execution side: entry, row and vector stores, row walk, multiply-accumulate,
// saturation and the result register. Depends on csmv_pkg.
module csmv_back
    import csmv_pkg::*;
#(
    parameter int ROWS    = 1024,
    parameter int COLS    = 1024,
    parameter int ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  cmd_t        cmd,
    input  logic        cmdq_empty,
    output logic        cmdq_pop,
    output logic        clearing,
    output result_t     result,
    output logic        empty,
    input  logic        pop
);

    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ECW = $clog2(ENTRIES + 1);
    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ROWRD = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    logic [31:0]    ent_val_mem [ENTRIES];
    logic [CAW-1:0] ent_col_mem [ENTRIES];
    logic [RAW-1:0] ent_row_mem [ENTRIES];
    logic [EAW-1:0] row_start_mem [ROWS];
    logic [ECW-1:0] row_len_mem [ROWS];
    logic [31:0]    vec_mem [COLS];

    logic [31:0]    ent_val_rd_reg;
    logic [CAW-1:0] ent_col_rd_reg;
    logic [RAW-1:0] ent_row_rd_reg;
    logic [EAW-1:0] row_start_rd_reg;
    logic [ECW-1:0] row_len_rd_reg;
    logic [31:0]    vec_rd_reg;

    logic [2:0]     state_reg, state_next;
    logic [RAW-1:0] clr_idx_reg, clr_idx_next;
    logic [9:0]     row_reg, row_next;
    logic [ECW-1:0] cnt_reg, cnt_next;
    logic [EAW-1:0] walk_k_reg, walk_k_next;
    logic [ECW-1:0] rem_reg, rem_next;
    logic           s1_valid_reg;
    logic           s2_valid_reg;
    logic           s3_valid_reg;
    logic [31:0]    s2_val_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]    row_offset_reg;
    logic           res_valid_reg;
    result_t        res_reg, res_next;

    logic           head_valid;
    logic           ent_we;
    logic           row_we;
    logic [RAW-1:0] row_waddr;
    logic [EAW-1:0] row_wstart;
    logic [ECW-1:0] row_wlen;
    logic           vec_we;
    logic [EAW-1:0] ent_raddr;
    logic           acc_clr;
    logic           res_load;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] total;
    logic           sat_hi;
    logic           sat_lo;

    assign head_valid = (state_reg == ST_IDLE) && !cmdq_empty;
    assign cmdq_pop   = head_valid;
    assign clearing   = state_reg == ST_CLEAR;
    assign ent_we     = head_valid && (cmd.kind == CMD_APPEND);
    assign vec_we     = head_valid && (cmd.kind == CMD_VECTOR);
    assign row_we     = ent_we || clearing;
    assign row_waddr  = clearing ? clr_idx_reg : RAW'(cmd.row);
    assign row_wstart = clearing ? '0 : EAW'(cmd.start);
    assign row_wlen   = clearing ? '0 : ECW'(cmd.len);
    assign ent_raddr  = (state_reg == ST_ROWRD) ? row_start_rd_reg : walk_k_reg;
    assign mul_a      = s2_val_reg;
    assign mul_b      = vec_rd_reg;
    assign total      = acc_reg + {{32{row_offset_reg[31]}}, row_offset_reg};
    assign sat_hi     = total > SAT_MAX;
    assign sat_lo     = total < SAT_MIN;
    assign result     = res_reg;
    assign empty      = !res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_val_mem[EAW'(cmd.pos)] <= cmd.value;
            ent_col_mem[EAW'(cmd.pos)] <= CAW'(cmd.col);
            ent_row_mem[EAW'(cmd.pos)] <= RAW'(cmd.row);
        end
        ent_val_rd_reg <= ent_val_mem[ent_raddr];
        ent_col_rd_reg <= ent_col_mem[ent_raddr];
        ent_row_rd_reg <= ent_row_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_start_mem[row_waddr] <= row_wstart;
            row_len_mem[row_waddr]   <= row_wlen;
        end
        row_start_rd_reg <= row_start_mem[RAW'(cmd.row)];
        row_len_rd_reg   <= row_len_mem[RAW'(cmd.row)];
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[CAW'(cmd.col)] <= cmd.value;
        end
        vec_rd_reg <= vec_mem[ent_col_rd_reg];
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        row_next     = row_reg;
        cnt_next     = cnt_reg;
        walk_k_next  = walk_k_reg;
        rem_next     = rem_reg;
        acc_clr      = 1'b0;
        res_load     = 1'b0;
        res_next.result_row = row_reg;
        res_next.dot_value  = sat_hi ? 32'sh7FFF_FFFF :
                              sat_lo ? 32'sh8000_0000 : total[31:0];
        res_next.saturated  = sat_hi || sat_lo;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == RAW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + RAW'(1);
                end
            end
            ST_IDLE:
            begin
                if (head_valid && (cmd.kind == CMD_ROW))
                begin
                    row_next   = cmd.row;
                    cnt_next   = ECW'(cmd.pos);
                    acc_clr    = 1'b1;
                    state_next = ST_ROWRD;
                end
                else if (head_valid && (cmd.kind == CMD_EMPTY_ROW))
                begin
                    row_next   = cmd.row;
                    acc_clr    = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_ROWRD:
            begin
                if ((row_len_rd_reg == '0) || (ECW'(row_start_rd_reg) >= cnt_reg))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    walk_k_next = row_start_rd_reg;
                    rem_next    = row_len_rd_reg;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:
            begin
                state_next = (ent_row_rd_reg == RAW'(row_reg)) ? ST_WALK : ST_DRAIN;
            end
            ST_WALK:
            begin
                walk_k_next = walk_k_reg + EAW'(1);
                rem_next    = rem_reg - ECW'(1);
                if (rem_reg == ECW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            row_reg        <= '0;
            cnt_reg        <= '0;
            walk_k_reg     <= '0;
            rem_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            row_offset_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            row_reg      <= row_next;
            cnt_reg      <= cnt_next;
            walk_k_reg   <= walk_k_next;
            rem_reg      <= rem_next;
            s1_valid_reg <= state_reg == ST_WALK;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cfg_we)
            begin
                row_offset_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_val_reg <= ent_val_rd_reg;
        prod_reg   <= mul_a * mul_b;
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            acc_reg <= acc_reg + (prod_reg >>> 24);
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
        else $error("row result formed with products still in flight");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmdq_pop)
        else $error("command taken during row store clear");

    a_s1_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("entry stage valid without a walk step");

    a_acc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWRD) |-> (acc_reg == '0))
        else $error("accumulator not cleared at row start");
`endif

endmodule

// File: rtl/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix times dense vector block.
// Instantiates csmv_front, csmv_cmdq and csmv_back; depends on csmv_pkg.
//
// Channel   Handshake            Payload
// input     push / full          item   (mode, row, col, value)
// result    empty / pop          result (result_row, dot_value, saturated)
// config    cfg_we               cfg_wdata (row_offset)
//
// Entry loads and vector writes are stored by the execution side as their commands pop; a clear
// only resets the entry count and open row in the input side.
// A row compute runs from accept to result through command pop, row lookup, check,
// a walk of one stored entry per cycle, a drain of the multiply pipeline and the load.
// After reset the row store is cleared row by row with full held high.
// A four-deep command queue lets loads be accepted while a row is computed.
module csr_sparse_matrix_vector_multiply
    import csmv_pkg::*;
#(
    parameter int ROWS    = 1024,
    parameter int COLS    = 1024,
    parameter int ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic cmdq_full;
    logic cmdq_empty;
    logic cmdq_pop;
    logic clearing;

    csmv_front #(
        .ROWS    (ROWS),
        .COLS    (COLS),
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .clearing  (clearing),
        .cmdq_full (cmdq_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    csmv_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (cmdq_pop),
        .rdata (head_cmd),
        .empty (cmdq_empty)
    );

    csmv_back #(
        .ROWS    (ROWS),
        .COLS    (COLS),
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (head_cmd),
        .cmdq_empty (cmdq_empty),
        .cmdq_pop   (cmdq_pop),
        .clearing   (clearing),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
